FILE: design/mste_pkg.sv
// shared types, constants and the morse code table for the symbol timing encoder
package mste_pkg;

    localparam int TICK_W = 15;
    localparam int CHAR_W = 8;
    localparam int CFG_IDX_W = 2;
    localparam int MAX_SYM = 5;
    localparam int SYM_IDX_W = 3;
    localparam int LEN_W = 3;
    localparam int IVL_IDX_W = 4;

    localparam logic [TICK_W-1:0] DOT_TICKS_RESET = 15'h0180;
    localparam logic [TICK_W-1:0] DASH_TICKS_RESET = 15'h0480;

    localparam logic [CFG_IDX_W-1:0] REG_DOT_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DASH_TICKS = 2'd1;

    localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;

    // one character: pattern bit k set means symbol k is a dash
    typedef struct packed {
        logic                 bad;
        logic [LEN_W-1:0]     len;
        logic [MAX_SYM-1:0]   pat;
    } t_code;

    localparam logic [LEN_W-1:0] LETTER_LEN [26] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
        3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
        3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
    };

    localparam logic [MAX_SYM-1:0] LETTER_PAT [26] = '{
        5'b00010, 5'b00001, 5'b00101, 5'b00001, 5'b00000, 5'b00100,
        5'b00011, 5'b00000, 5'b00000, 5'b01110, 5'b00101, 5'b00010,
        5'b00011, 5'b00001, 5'b00111, 5'b00110, 5'b01011, 5'b00010,
        5'b00000, 5'b00001, 5'b00100, 5'b01000, 5'b00110, 5'b01001,
        5'b01101, 5'b00011
    };

    localparam logic [MAX_SYM-1:0] DIGIT_PAT [10] = '{
        5'b11111, 5'b11110, 5'b11100, 5'b11000, 5'b10000,
        5'b00000, 5'b00001, 5'b00011, 5'b00111, 5'b01111
    };

    function automatic t_code morse_lookup(input logic [CHAR_W-1:0] ch);
        t_code      c;
        logic [4:0] li;
        logic [3:0] di;
        li = 5'(ch - CHAR_A);
        di = 4'(ch - CHAR_ZERO);
        c.bad = 1'b1;
        c.len = 3'd1;
        c.pat = '0;
        case (ch) inside
            [8'h41:8'h5A]: begin
                c.bad = 1'b0;
                c.len = LETTER_LEN[li];
                c.pat = LETTER_PAT[li];
            end
            [8'h30:8'h39]: begin
                c.bad = 1'b0;
                c.len = LEN_W'(MAX_SYM);
                c.pat = DIGIT_PAT[di];
            end
            default: begin
                c.bad = 1'b1;
            end
        endcase
        return c;
    endfunction

endpackage

FILE: design/morse_symbol_timing_encoder_core.sv
// the first interval of a character reaches the result ports through the input and result registers
// throughput: one interval per cycle; a character gives two intervals per symbol (up to 10),
// an uncoded character one; the next request is taken during the last interval
// the interval sequencer sets this rate; the receiver cannot stall the block
// synchronous active-low reset returns dot and dash lengths to 384 and 1152 ticks
module morse_symbol_timing_encoder_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [mste_pkg::CHAR_W-1:0]    i_char_code,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mste_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mste_pkg::TICK_W-1:0]    i_cfg_data,
    output logic                           o_result_valid,
    output logic [mste_pkg::TICK_W-1:0]    o_interval_ticks,
    output logic                           o_tone_on,
    output logic                           o_invalid_char,
    output logic                           o_last_interval
);
    import mste_pkg::*;

    logic [TICK_W-1:0] r_dot_ticks;
    logic [TICK_W-1:0] r_dash_ticks;
    logic              load;
    t_code             code;

    assign o_cfg_ready = 1'b1;
    assign load        = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_ticks  <= DOT_TICKS_RESET;
            r_dash_ticks <= DASH_TICKS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_DOT_TICKS:  r_dot_ticks  <= i_cfg_data;
                REG_DASH_TICKS: r_dash_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mste_decode u_decode (
        .i_clk       (i_clk),
        .i_load      (load),
        .i_char_code (i_char_code),
        .o_code      (code)
    );

    mste_serial u_serial (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (load),
        .i_code           (code),
        .i_dot_ticks      (r_dot_ticks),
        .i_dash_ticks     (r_dash_ticks),
        .o_busy           (busy),
        .o_result_valid   (o_result_valid),
        .o_interval_ticks (o_interval_ticks),
        .o_tone_on        (o_tone_on),
        .o_invalid_char   (o_invalid_char),
        .o_last_interval  (o_last_interval)
    );

endmodule

FILE: design/mste_decode.sv
// input register: looks up the morse code of an accepted character
module mste_decode (
    input  logic                      i_clk,
    input  logic                      i_load,
    input  logic [mste_pkg::CHAR_W-1:0] i_char_code,
    output mste_pkg::t_code           o_code
);
    import mste_pkg::*;

    t_code r_code;
    t_code n_code;

    assign n_code = i_load ? morse_lookup(i_char_code) : r_code;

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
    end

    assign o_code = r_code;

endmodule

FILE: design/mste_serial.sv
// interval sequencer and result register
module mste_serial (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  mste_pkg::t_code             i_code,
    input  logic [mste_pkg::TICK_W-1:0] i_dot_ticks,
    input  logic [mste_pkg::TICK_W-1:0] i_dash_ticks,
    output logic                        o_busy,
    output logic                        o_result_valid,
    output logic [mste_pkg::TICK_W-1:0] o_interval_ticks,
    output logic                        o_tone_on,
    output logic                        o_invalid_char,
    output logic                        o_last_interval
);
    import mste_pkg::*;

    logic                 r_active;
    logic [IVL_IDX_W-1:0] r_idx;
    logic                 n_active;
    logic [IVL_IDX_W-1:0] n_idx;

    logic                 r_stb;
    logic [TICK_W-1:0]    r_ticks;
    logic                 r_tone;
    logic                 r_bad;
    logic                 r_last;

    logic [SYM_IDX_W-1:0] sym;
    logic                 gap;
    logic                 last_sym;
    logic                 cur_last;
    logic [TICK_W-1:0     ] cur_ticks;

    // even index is the tone, odd index the gap after it
    assign sym      = r_idx[IVL_IDX_W-1:1];
    assign gap      = r_idx[0];
    assign last_sym = (sym == SYM_IDX_W'(i_code.len - 3'd1));
    assign cur_last = i_code.bad | (gap & last_sym);

    always_comb begin
        if (i_code.bad) begin
            cur_ticks = '0;
        end else if (!gap) begin
            cur_ticks = i_code.pat[sym] ? i_dash_ticks : i_dot_ticks;
        end else begin
            cur_ticks = last_sym ? i_dash_ticks : i_dot_ticks;
        end
    end

    always_comb begin
        n_active = r_active;
        n_idx    = r_idx;
        if (i_load) begin
            n_active = 1'b1;
            n_idx    = '0;
        end else if (r_active && cur_last) begin
            n_active = 1'b0;
        end else if (r_active) begin
            n_idx = r_idx + IVL_IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
            r_stb    <= 1'b0;
        end else begin
            r_active <= n_active;
            r_idx    <= n_idx;
            r_stb    <= r_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_active) begin
            r_ticks <= cur_ticks;
            r_tone  <= ~i_code.bad & ~gap;
            r_bad   <= i_code.bad;
            r_last  <= cur_last;
        end
    end

    // free during the last interval so the next request follows directly
    assign o_busy           = r_active & ~cur_last;
    assign o_result_valid   = r_stb;
    assign o_interval_ticks = r_ticks;
    assign o_tone_on        = r_tone;
    assign o_invalid_char   = r_bad;
    assign o_last_interval  = r_last;

endmodule
